/* rtl/status_led_blink_sequencer_top_defines.svh */
// Assertion macros shared by the sequencer RTL.
// Each macro expects signals named clk and arst_n in the module that uses it.
`ifndef STATUS_LED_BLINK_SEQUENCER_TOP_DEFINES_SVH
`define STATUS_LED_BLINK_SEQUENCER_TOP_DEFINES_SVH

// Same-cycle implication.
`define SLBS_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("slbs: same-cycle check failed");

// Next-cycle implication.
`define SLBS_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("slbs: next-cycle check failed");

`endif

/* rtl/slbs_pkg.sv */
package slbs_pkg;

	typedef struct packed {
		logic       gyro_cal_active;
		logic       mag_cal_active;
		logic       armed_ready;
		logic [7:0] link_rate;
		logic [1:0] flight_mode;
		logic [1:0] control_mode;
		logic [1:0] mag_cal_stage;
	} in_t;

	typedef struct packed {
		logic red_on;
		logic green_on;
		logic blue_on;
		logic clear_mag_stage;
	} out_t;

	typedef struct packed {
		logic [6:0]  blink_unit;
		logic [7:0]  link_rate_threshold;
		logic [7:0]  end_gap_threshold;
		logic [15:0] cal_hold_threshold;
	} cfg_t;

	// Register indexes (byte address is four times the index).
	localparam logic [1:0] REG_BLINK_UNIT = 2'd0;
	localparam logic [1:0] REG_LINK_THR   = 2'd1;
	localparam logic [1:0] REG_GAP_THR    = 2'd2;
	localparam logic [1:0] REG_HOLD_THR   = 2'd3;

	localparam logic [6:0]  RST_BLINK_UNIT = 7'd2;
	localparam logic [7:0]  RST_LINK_THR   = 8'd5;
	localparam logic [7:0]  RST_GAP_THR    = 8'd20;
	localparam logic [15:0] RST_HOLD_THR   = 16'd200;

	// Colour codes: bit 0 red, bit 1 green, bit 2 blue.
	localparam logic [2:0] COL_BLACK  = 3'd0;
	localparam logic [2:0] COL_RED    = 3'd1;
	localparam logic [2:0] COL_GREEN  = 3'd2;
	localparam logic [2:0] COL_YELLOW = 3'd3;
	localparam logic [2:0] COL_BLUE   = 3'd4;
	localparam logic [2:0] COL_WHITE  = 3'd7;

	localparam logic [1:0] MODE_IDLE = 2'd0;
	localparam logic [1:0] MODE_GYRO = 2'd1;
	localparam logic [1:0] MODE_MAG  = 2'd2;

	localparam logic [4:0] STEP_WAIT      = 5'd0;
	localparam logic [4:0] STEP_ARM_LONG  = 5'd1;
	localparam logic [4:0] STEP_ARM_GAP   = 5'd2;
	localparam logic [4:0] STEP_ARM_SHORT = 5'd3;
	localparam logic [4:0] STEP_LINK1A    = 5'd4;
	localparam logic [4:0] STEP_LINK1B    = 5'd5;
	localparam logic [4:0] STEP_DARK1A    = 5'd6;
	localparam logic [4:0] STEP_DARK1B    = 5'd7;
	localparam logic [4:0] STEP_LINK2A    = 5'd8;
	localparam logic [4:0] STEP_LINK2B    = 5'd9;
	localparam logic [4:0] STEP_DARK2A    = 5'd10;
	localparam logic [4:0] STEP_DARK2B    = 5'd11;
	localparam logic [4:0] STEP_LINK3A    = 5'd12;
	localparam logic [4:0] STEP_LINK3B    = 5'd13;
	localparam logic [4:0] STEP_DARK3A    = 5'd14;
	localparam logic [4:0] STEP_DARK3B    = 5'd15;
	localparam logic [4:0] STEP_FMODE_A   = 5'd16;
	localparam logic [4:0] STEP_FMODE_B   = 5'd17;
	localparam logic [4:0] STEP_CMODE_A   = 5'd18;
	localparam logic [4:0] STEP_CMODE_B   = 5'd19;
	localparam logic [4:0] STEP_END_GAP   = 5'd20;

	localparam logic [1:0] GYRO_WAIT = 2'd0;
	localparam logic [1:0] GYRO_RUN  = 2'd1;
	localparam logic [1:0] GYRO_HOLD = 2'd2;

	localparam logic [1:0] MAG_WAIT = 2'd0;
	localparam logic [1:0] MAG_RUN  = 2'd1;
	localparam logic [1:0] MAG_DONE = 2'd2;
	localparam logic [1:0] MAG_HOLD = 2'd3;

	localparam logic [1:0] FLIGHT_BLUE  = 2'd0;
	localparam logic [1:0] FLIGHT_WHITE = 2'd1;
	localparam logic [1:0] FLIGHT_GREEN = 2'd2;

	localparam logic [1:0] CTRL_DARK_A = 2'd0;
	localparam logic [1:0] CTRL_DARK_B = 2'd1;

	localparam logic [1:0] STAGE_RESTART = 2'd1;
	localparam logic [1:0] STAGE_DONE    = 2'd2;

endpackage

/* rtl/status_led_blink_sequencer_top.sv */
// Channel  | Handshake                   | Payload
// ---------+-----------------------------+------------------------------------
// item     | item_valid / item_stall     | in_t: status flags for one tick
// result   | result_valid / result_stall | out_t: LED colour and stage clear
// config   | psel, penable, pwrite       | paddr / pwdata / prdata, 4 registers
//
// One transaction per clock cycle is sustained unless a stall holds a full result
// register; each tick needs a single pass through the sequencer logic between the
// input register and the result register, where the result of an item is loaded
// once that register is free or being emptied.
// Reset (arst_n low) clears all sequencer state, the valid flags and the
// configuration registers to their documented defaults.
// A stall on a full result register holds it and, while a transaction
// also waits in the input register, raises item_stall in that same cycle.

module status_led_blink_sequencer_top
	import slbs_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	output logic        item_stall,
	input  in_t         item,
	output logic        result_valid,
	input  logic        result_stall,
	output out_t        result,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	// Stage 1 holds the accepted transaction; stage 2 holds its result.
	in_t  item_s1;
	logic valid_s1;
	out_t result_s2;
	logic valid_s2;

	cfg_t cfg;
	out_t core_result;
	logic advance;

	// The tick is evaluated when the result register is free or being emptied.
	assign advance    = valid_s1 && (!valid_s2 || !result_stall);
	assign item_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!item_stall) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!item_stall && item_valid) begin
			item_s1 <= item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (!result_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_s2 <= core_result;
		end
	end

	assign result_valid = valid_s2;
	assign result       = result_s2;

	slbs_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	slbs_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.step_en (advance),
		.item    (item_s1),
		.cfg     (cfg),
		.result  (core_result)
	);

endmodule

/* rtl/slbs_regs.sv */
module slbs_regs
	import slbs_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	output cfg_t        cfg
);

	cfg_t       cfg_q;
	logic       wr_en;
	logic [1:0] reg_idx;

	assign pready  = 1'b1;
	assign wr_en   = psel & penable & pwrite;
	assign reg_idx = paddr[3:2];
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.blink_unit          <= RST_BLINK_UNIT;
			cfg_q.link_rate_threshold <= RST_LINK_THR;
			cfg_q.end_gap_threshold   <= RST_GAP_THR;
			cfg_q.cal_hold_threshold  <= RST_HOLD_THR;
		end else if (wr_en) begin
			case (reg_idx)
				REG_BLINK_UNIT: cfg_q.blink_unit          <= pwdata[6:0];
				REG_LINK_THR:   cfg_q.link_rate_threshold <= pwdata[7:0];
				REG_GAP_THR:    cfg_q.end_gap_threshold   <= pwdata[7:0];
				REG_HOLD_THR:   cfg_q.cal_hold_threshold  <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_BLINK_UNIT: prdata = {25'd0, cfg_q.blink_unit};
			REG_LINK_THR:   prdata = {24'd0, cfg_q.link_rate_threshold};
			REG_GAP_THR:    prdata = {24'd0, cfg_q.end_gap_threshold};
			REG_HOLD_THR:   prdata = {16'd0, cfg_q.cal_hold_threshold};
			default:        prdata = 32'd0;
		endcase
	end

endmodule

/* rtl/slbs_core.sv */
`include "status_led_blink_sequencer_top_defines.svh"

module slbs_core
	import slbs_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic step_en,
	input  in_t  item,
	input  cfg_t cfg,
	output out_t result
);

	logic [1:0]  top_mode_q, top_mode_n;
	logic [4:0]  blink_step_q, blink_step_n;
	logic [7:0]  blink_count_q, blink_count_n;
	logic [1:0]  gyro_step_q, gyro_step_n;
	logic [1:0]  mag_step_q, mag_step_n;
	logic [15:0] hold_count_q, hold_count_n;
	logic [2:0]  colour_q, colour_n;

	logic [2:0]  arm_col, link_col;
	logic [4:0]  cur_step;
	logic        timed;
	logic [7:0]  timed_thr;
	logic [4:0]  timed_next;
	logic        clear;

	assign arm_col  = item.armed_ready ? COL_RED : COL_WHITE;
	assign link_col = (item.link_rate > cfg.link_rate_threshold) ? COL_WHITE : COL_BLACK;

	// The three sub-machines act in order within one tick; later writes win.
	always_comb begin
		top_mode_n    = top_mode_q;
		blink_step_n  = blink_step_q;
		blink_count_n = blink_count_q;
		gyro_step_n   = gyro_step_q;
		mag_step_n    = mag_step_q;
		hold_count_n  = hold_count_q;
		colour_n      = colour_q;
		clear         = 1'b0;
		timed         = 1'b0;
		timed_thr     = {1'b0, cfg.blink_unit};
		timed_next    = blink_step_q + 5'd1;

		if (top_mode_q == MODE_IDLE) begin
			if (item.gyro_cal_active) begin
				blink_step_n = STEP_WAIT;
				top_mode_n   = MODE_GYRO;
			end else if (item.mag_cal_active) begin
				blink_step_n = STEP_WAIT;
				top_mode_n   = MODE_MAG;
			end
		end

		cur_step = blink_step_n;
		case (cur_step)
			STEP_WAIT: begin
				if (top_mode_n == MODE_IDLE) begin
					blink_step_n  = STEP_ARM_LONG;
					blink_count_n = 8'd0;
				end
			end
			STEP_ARM_LONG: begin
				colour_n  = arm_col;
				timed     = 1'b1;
				timed_thr = {cfg.blink_unit, 1'b0};
			end
			STEP_ARM_SHORT: begin
				colour_n = arm_col;
				timed    = 1'b1;
			end
			STEP_LINK1A, STEP_LINK1B, STEP_LINK2A, STEP_LINK2B,
			STEP_LINK3A, STEP_LINK3B: begin
				colour_n = link_col;
				timed    = 1'b1;
			end
			STEP_ARM_GAP, STEP_DARK1A, STEP_DARK1B, STEP_DARK2A, STEP_DARK2B,
			STEP_DARK3A, STEP_DARK3B: begin
				colour_n = COL_BLACK;
				timed    = 1'b1;
			end
			STEP_FMODE_A, STEP_FMODE_B: begin
				if (item.flight_mode == FLIGHT_BLUE)
					colour_n = COL_BLUE;
				else if (item.flight_mode == FLIGHT_WHITE)
					colour_n = COL_WHITE;
				else if (item.flight_mode == FLIGHT_GREEN)
					colour_n = COL_GREEN;
				timed = 1'b1;
			end
			STEP_CMODE_A, STEP_CMODE_B: begin
				if (item.control_mode inside {CTRL_DARK_A, CTRL_DARK_B})
					colour_n = COL_BLACK;
				timed = 1'b1;
			end
			STEP_END_GAP: begin
				colour_n   = COL_BLACK;
				timed      = 1'b1;
				timed_thr  = cfg.end_gap_threshold;
				timed_next = STEP_WAIT;
			end
			default: blink_step_n = STEP_WAIT;
		endcase

		if (timed) begin
			if (blink_count_q > timed_thr) begin
				blink_step_n  = timed_next;
				blink_count_n = 8'd0;
			end else begin
				blink_count_n = blink_count_q + 8'd1;
			end
		end

		case (gyro_step_q)
			GYRO_WAIT: begin
				if (top_mode_n == MODE_GYRO) begin
					gyro_step_n = GYRO_RUN;
					colour_n    = COL_YELLOW;
				end
			end
			GYRO_RUN: begin
				if (!item.gyro_cal_active) begin
					gyro_step_n = GYRO_HOLD;
					colour_n    = COL_BLACK;
				end
			end
			GYRO_HOLD: begin
				if (hold_count_n > cfg.cal_hold_threshold) begin
					hold_count_n = 16'd0;
					gyro_step_n  = GYRO_WAIT;
					top_mode_n   = MODE_IDLE;
				end else begin
					hold_count_n = hold_count_n + 16'd1;
				end
			end
			default: gyro_step_n = GYRO_WAIT;
		endcase

		case (mag_step_q)
			MAG_WAIT: begin
				if (top_mode_n == MODE_MAG) begin
					mag_step_n = MAG_RUN;
					colour_n   = COL_BLUE;
				end
			end
			MAG_RUN: begin
				if (item.mag_cal_stage == STAGE_DONE) begin
					mag_step_n = MAG_DONE;
					colour_n   = COL_WHITE;
				end
			end
			MAG_DONE: begin
				if (!item.mag_cal_active) begin
					mag_step_n = MAG_HOLD;
					colour_n   = COL_GREEN;
				end else if (item.mag_cal_stage == STAGE_RESTART) begin
					mag_step_n = MAG_RUN;
					colour_n   = COL_YELLOW;
				end
			end
			default: begin
				// Hold after magnetometer calibration; the hold counter is shared.
				if (hold_count_n > cfg.cal_hold_threshold) begin
					hold_count_n = 16'd0;
					mag_step_n   = MAG_WAIT;
					clear        = 1'b1;
					top_mode_n   = MODE_IDLE;
				end else begin
					hold_count_n = hold_count_n + 16'd1;
				end
			end
		endcase
	end

	assign result.red_on          = colour_n[0];
	assign result.green_on        = colour_n[1];
	assign result.blue_on         = colour_n[2];
	assign result.clear_mag_stage = clear;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			top_mode_q    <= MODE_IDLE;
			blink_step_q  <= STEP_WAIT;
			blink_count_q <= 8'd0;
			gyro_step_q   <= GYRO_WAIT;
			mag_step_q    <= MAG_WAIT;
			hold_count_q  <= 16'd0;
			colour_q      <= COL_BLACK;
		end else if (step_en) begin
			top_mode_q    <= top_mode_n;
			blink_step_q  <= blink_step_n;
			blink_count_q <= blink_count_n;
			gyro_step_q   <= gyro_step_n;
			mag_step_q    <= mag_step_n;
			hold_count_q  <= hold_count_n;
			colour_q      <= colour_n;
		end
	end

	`SLBS_ASSERT_NOW(a_gyro_owns_mode, gyro_step_q != GYRO_WAIT, top_mode_q == MODE_GYRO)
	`SLBS_ASSERT_NOW(a_mag_owns_mode, mag_step_q != MAG_WAIT, top_mode_q == MODE_MAG)
	`SLBS_ASSERT_NOW(a_blink_only_idle, blink_step_q != STEP_WAIT, top_mode_q == MODE_IDLE)
	`SLBS_ASSERT_NEXT(a_clear_shows_green, step_en && clear, colour_q == COL_GREEN)

endmodule
